[rtl/assert_macros.svh]
// assertion helpers shared by the rtl files
// all of them sample on clk and are off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/cde_pkg.sv]
// ----------------------------------------------------------------------------
// cde_pkg
// Types, constants and the UTF-8 encoder shared by the cell diff emitter.
// ----------------------------------------------------------------------------
package cde_pkg;

	typedef enum logic [1:0] {
		TK_MOVE  = 2'd0,
		TK_STYLE = 2'd1,
		TK_TEXT  = 2'd2,
		TK_CLEAR = 2'd3
	} token_kind_t;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;

	localparam logic [20:0] CP_MAX_1B = 21'h00007F;
	localparam logic [20:0] CP_MAX_2B = 21'h0007FF;
	localparam logic [20:0] CP_MAX_3B = 21'h00FFFF;
	localparam logic [20:0] CP_MAX    = 21'h10FFFF;

	localparam logic [7:0] LEAD_2B = 8'hC0;
	localparam logic [7:0] LEAD_3B = 8'hE0;
	localparam logic [7:0] LEAD_4B = 8'hF0;
	localparam logic [7:0] CONT_B  = 8'h80;

	typedef struct packed {
		logic [2:0]      n;
		logic [3:0][7:0] b;
	} utf8_t;

	// one queued item: what the back end still has to send
	typedef struct packed {
		logic            clear;
		logic            move;
		logic            style_chg;
		logic [2:0]      nbytes;
		logic [8:0]      move_row;
		logic [8:0]      move_col;
		logic [31:0]     style;
		logic [3:0][7:0] bytes;
	} job_t;

	// byte 0 goes out first
	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t r;
		r.n = 3'd0;
		r.b = '0;
		if (cp <= CP_MAX_1B) begin
			r.n    = 3'd1;
			r.b[0] = cp[7:0];
		end else if (cp <= CP_MAX_2B) begin
			r.n    = 3'd2;
			r.b[0] = LEAD_2B | {3'b000, cp[10:6]};
			r.b[1] = CONT_B | {2'b00, cp[5:0]};
		end else if (cp <= CP_MAX_3B) begin
			r.n    = 3'd3;
			r.b[0] = LEAD_3B | {4'b0000, cp[15:12]};
			r.b[1] = CONT_B | {2'b00, cp[11:6]};
			r.b[2] = CONT_B | {2'b00, cp[5:0]};
		end else if (cp <= CP_MAX) begin
			r.n    = 3'd4;
			r.b[0] = LEAD_4B | {5'b00000, cp[20:18]};
			r.b[1] = CONT_B | {2'b00, cp[17:12]};
			r.b[2] = CONT_B | {2'b00, cp[11:6]};
			r.b[3] = CONT_B | {2'b00, cp[5:0]};
		end
		return r;
	endfunction

endpackage

[rtl/cde_queue.sv]
// ----------------------------------------------------------------------------
// cde_queue
// Small job queue between the classifying front end and the token back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cde_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cde_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output cde_pkg::job_t dout,
	output logic          empty
);
	import cde_pkg::*;

	job_t                 mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q;
	logic [Q_PTR_W-1:0]   rd_q;
	logic [Q_PTR_W:0]     count_q;

	assign full  = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (Q_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (Q_PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_IMPLY(a_queue_ptrs, count_q == '0, wr_q == rd_q, "queue pointers disagree with count")

endmodule

[rtl/cde_front.sv]
// ----------------------------------------------------------------------------
// cde_front
// Tracks raster position, skip, cursor and style; turns each cell pair into
// a job for the back end or drops it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cde_front #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256,
	parameter int STYLE_BITS  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [8:0]    cfg_columns,
	input  logic [8:0]    cfg_rows,
	input  logic          push,
	output logic          full,
	input  logic          action,
	input  logic [20:0]   old_codepoint,
	input  logic [31:0]   old_style,
	input  logic [1:0]    old_width,
	input  logic [20:0]   new_codepoint,
	input  logic [31:0]   new_style,
	input  logic [1:0]    new_width,
	input  logic          q_full,
	output logic          q_push,
	output cde_pkg::job_t q_job
);
	import cde_pkg::*;

	localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam logic [8:0] COLS_LIM = 9'(MAX_COLUMNS);
	localparam logic [8:0] ROWS_LIM = 9'(MAX_ROWS);

	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic                  skip_q;
	logic                  known_q;
	logic [ROW_W-1:0]      crow_q;
	logic [9:0]            ccol_q;
	logic [STYLE_BITS-1:0] cur_style_q;

	logic [8:0]            cols_eff;
	logic [8:0]            rows_eff;
	logic [8:0]            col_inc;
	logic [8:0]            row_inc;
	logic                  wrap_col;
	logic                  wrap_row;
	logic [COL_W-1:0]      col_adv;
	logic [ROW_W-1:0]      row_adv;
	logic [STYLE_BITS-1:0] ost;
	logic [STYLE_BITS-1:0] nst;
	logic                  same;
	logic                  mv;
	logic                  st;
	utf8_t                 enc;
	logic [1:0]            w;
	logic [9:0]            ccol_next;
	logic                  take;
	logic                  changed;

	// out-of-range sizes act as the nearest legal value
	assign cols_eff = (cfg_columns == '0) ? 9'd1 : (cfg_columns > COLS_LIM) ? COLS_LIM : cfg_columns;
	assign rows_eff = (cfg_rows == '0) ? 9'd1 : (cfg_rows > ROWS_LIM) ? ROWS_LIM : cfg_rows;

	assign col_inc  = 9'(col_q) + 9'd1;
	assign row_inc  = 9'(row_q) + 9'd1;
	assign wrap_col = (col_inc >= cols_eff);
	assign wrap_row = (row_inc >= rows_eff);
	assign col_adv  = wrap_col ? '0 : col_inc[COL_W-1:0];
	assign row_adv  = wrap_col ? (wrap_row ? '0 : row_inc[ROW_W-1:0]) : row_q;

	assign ost  = old_style[STYLE_BITS-1:0];
	assign nst  = new_style[STYLE_BITS-1:0];
	assign same = (old_codepoint == new_codepoint) && (ost == nst) && (old_width == new_width);
	assign mv   = !known_q || (crow_q != row_q) || (ccol_q != 10'(col_q));
	assign st   = (cur_style_q != nst);
	assign enc  = utf8_encode(new_codepoint);
	assign w    = (new_width == 2'd3) ? 2'd2 : new_width;

	assign ccol_next = (mv ? 10'(col_q) : ccol_q) + 10'(w);

	assign full    = q_full;
	assign take    = push && !full;
	assign changed = !action && !skip_q && !same;
	assign q_push  = take && (action || (changed && (mv || st || (enc.n != '0))));

	always_comb begin
		q_job           = '0;
		q_job.clear     = action;
		q_job.move      = !action && mv;
		q_job.style_chg = !action && st;
		q_job.nbytes    = action ? 3'd0 : enc.n;
		q_job.move_row  = 9'(row_q) + 9'd1;
		q_job.move_col  = 9'(col_q) + 9'd1;
		q_job.style     = 32'(nst);
		q_job.bytes     = enc.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			skip_q      <= 1'b0;
			known_q     <= 1'b0;
			crow_q      <= '0;
			ccol_q      <= '0;
			cur_style_q <= '0;
		end else if (take) begin
			if (action) begin
				col_q       <= '0;
				row_q       <= '0;
				skip_q      <= 1'b0;
				known_q     <= 1'b0;
				crow_q      <= '0;
				ccol_q      <= '0;
				cur_style_q <= '0;
			end else begin
				col_q  <= col_adv;
				row_q  <= row_adv;
				skip_q <= 1'b0;
				if (changed) begin
					known_q     <= 1'b1;
					crow_q      <= row_q;
					ccol_q      <= ccol_next;
					cur_style_q <= nst;
					// a wide cell covers the next one unless the row ends here
					skip_q      <= w[1] && !wrap_col;
				end
			end
		end
	end

	`ASSERT_IMPLY(a_push_room, q_push, !q_full, "job pushed into a full queue")
	`ASSERT_CLK(a_redraw_home, take && action |=> (col_q == '0) && (row_q == '0) && !known_q && !skip_q, "redraw did not reset position")

endmodule

[rtl/cde_back.sv]
// ----------------------------------------------------------------------------
// cde_back
// Expands jobs into output register tokens, one per cycle unless pop stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cde_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  cde_pkg::job_t q_job,
	output logic          q_pop,
	output logic          empty,
	input  logic          pop,
	output logic [1:0]    token_kind,
	output logic [8:0]    move_row,
	output logic [8:0]    move_column,
	output logic [31:0]   style_word,
	output logic [7:0]    text_byte,
	output logic          last_token
);
	import cde_pkg::*;

	job_t        wk_q;
	logic        wk_v_q;
	logic [2:0]  bi_q;

	logic        out_v_q;
	token_kind_t kind_q;
	logic [8:0]  row_q;
	logic [8:0]  col_q;
	logic [31:0] style_q;
	logic [7:0]  byte_q;
	logic        last_q;

	token_kind_t t_kind;
	logic [8:0]  t_row;
	logic [8:0]  t_col;
	logic [31:0] t_style;
	logic [7:0]  t_byte;
	logic        t_last;
	logic        out_free;
	logic        adv;
	logic        load;

	assign out_free = !out_v_q || pop;
	assign adv      = wk_v_q && out_free;
	assign load     = !wk_v_q || (adv && t_last);
	assign q_pop    = load && !q_empty;

	// token order: clear, move, style, then text bytes
	always_comb begin
		t_kind  = TK_TEXT;
		t_row   = '0;
		t_col   = '0;
		t_style = '0;
		t_byte  = '0;
		t_last  = 1'b0;
		if (wk_q.clear) begin
			t_kind = TK_CLEAR;
			t_last = 1'b1;
		end else if (wk_q.move) begin
			t_kind = TK_MOVE;
			t_row  = wk_q.move_row;
			t_col  = wk_q.move_col;
			t_last = !wk_q.style_chg && (wk_q.nbytes == '0);
		end else if (wk_q.style_chg) begin
			t_kind  = TK_STYLE;
			t_style = wk_q.style;
			t_last  = (wk_q.nbytes == '0);
		end else begin
			t_kind = TK_TEXT;
			t_byte = wk_q.bytes[bi_q[1:0]];
			t_last = ((bi_q + 3'd1) == wk_q.nbytes);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wk_v_q <= 1'b0;
			bi_q   <= '0;
		end else if (load) begin
			wk_v_q <= !q_empty;
			bi_q   <= '0;
		end else if (adv && !wk_q.clear && !wk_q.move && !wk_q.style_chg) begin
			bi_q <= bi_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			wk_q <= q_job;
		end else if (adv) begin
			if (wk_q.clear) begin
				wk_q.clear <= 1'b0;
			end else if (wk_q.move) begin
				wk_q.move <= 1'b0;
			end else if (wk_q.style_chg) begin
				wk_q.style_chg <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q  <= t_kind;
			row_q   <= t_row;
			col_q   <= t_col;
			style_q <= t_style;
			byte_q  <= t_byte;
			last_q  <= t_last;
		end
	end

	assign empty       = !out_v_q;
	assign token_kind  = kind_q;
	assign move_row    = row_q;
	assign move_column = col_q;
	assign style_word  = style_q;
	assign text_byte   = byte_q;
	assign last_token  = last_q;

	`ASSERT_IMPLY(a_clear_alone, wk_v_q && wk_q.clear, !wk_q.move && !wk_q.style_chg && (wk_q.nbytes == '0), "clear job carries other tokens")
	`ASSERT_IMPLY(a_clear_last, out_v_q && (kind_q == TK_CLEAR), last_q, "clear token not marked last")

endmodule

[rtl/cell_diff_utf8_emitter.sv]
// ----------------------------------------------------------------------------
// cell_diff_utf8_emitter
// Screen cell diff to cursor-move, style and UTF-8 text tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (push/full): one old/new cell pair per item in raster
//   order, or a redraw item (action high) that homes the position, forgets
//   the cursor, resets the style and yields one clear token.
//   Result channel (empty/pop): tokens, oldest first; last_token marks the
//   final token of an item. Unchanged and covered cells yield nothing.
//   APB port: screen_columns at 0x0, screen_rows at 0x4; write only while idle.
// Timing:
//   An item is classified in the cycle it is taken; its job goes through
//   the job queue and the work register before its first token is in the
//   output register. Items enter at one per cycle while the four-entry job
//   queue has room; tokens leave at one per cycle while the receiver pops.
// Reset clears position, cursor, style and queue; sizes return to 80 x 24.
// When the receiver stalls, the output register holds, the queue fills and
// full rises; unchanged cells still pass while the queue is not full.
// ----------------------------------------------------------------------------
module cell_diff_utf8_emitter #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256,
	parameter int STYLE_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [20:0] old_codepoint,
	input  logic [31:0] old_style,
	input  logic [1:0]  old_width,
	input  logic [20:0] new_codepoint,
	input  logic [31:0] new_style,
	input  logic [1:0]  new_width,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  token_kind,
	output logic [8:0]  move_row,
	output logic [8:0]  move_column,
	output logic [31:0] style_word,
	output logic [7:0]  text_byte,
	output logic        last_token
);
	import cde_pkg::*;

	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	logic [8:0] cols_q;
	logic [8:0] rows_q;
	logic       cfg_wr;
	logic       q_full;
	logic       q_empty;
	logic       q_push;
	logic       q_pop;
	job_t       q_in;
	job_t       q_out;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 9'd80;
			rows_q <= 9'd24;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_COLUMNS: cols_q <= pwdata[8:0];
				REG_ROWS:    rows_q <= pwdata[8:0];
				default:     cols_q <= cols_q;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_ROWS) ? {23'd0, rows_q} : {23'd0, cols_q};

	cde_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.STYLE_BITS  (STYLE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_columns   (cols_q),
		.cfg_rows      (rows_q),
		.push          (push),
		.full          (full),
		.action        (action),
		.old_codepoint (old_codepoint),
		.old_style     (old_style),
		.old_width     (old_width),
		.new_codepoint (new_codepoint),
		.new_style     (new_style),
		.new_width     (new_width),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_job         (q_in)
	);

	cde_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_out),
		.empty  (q_empty)
	);

	cde_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_job       (q_out),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.token_kind  (token_kind),
		.move_row    (move_row),
		.move_column (move_column),
		.style_word  (style_word),
		.text_byte   (text_byte),
		.last_token  (last_token)
	);

endmodule
